### rtl/gsp_pkg.sv
`timescale 1ns / 1ps
package gsp_pkg;

  localparam int ADC_BITS_DEF  = 10;
  localparam int MAX_GROUP_DEF = 255;

  localparam int ADC_FIELD_W = 10;
  localparam int RES_W       = 24;
  localparam int PPM_W       = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int SUM_W       = 32;
  localparam int CNT_W       = 8;

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 16;
  localparam int LOG_IW = 32;
  localparam int LOG_OW = 21;

  localparam logic [RES_W-1:0] RES_MAX  = '1;
  localparam logic [PPM_W-1:0] PPM_MAX  = '1;
  localparam logic [RES_W-1:0] RO_RESET = 24'd10240;

  localparam logic [14:0] LOG10_OF_2_Q16 = 15'd19728;
  localparam logic [17:0] LOG2_OF_10_Q16 = 18'd217706;

  localparam logic [7:0]  LOAD_RES_RESET  = 8'd5;
  localparam logic [15:0] CLEAN_AIR_RESET = 16'd2516;
  localparam logic [7:0]  CAL_COUNT_RESET = 8'd50;
  localparam logic [7:0]  READ_COUNT_RESET = 8'd5;
  localparam logic [47:0] LPG_RESET   = 48'd40462943320187;
  localparam logic [47:0] CO_RESET    = 48'd40463080225423;
  localparam logic [47:0] SMOKE_RESET = 48'd40463029238006;

  localparam logic KIND_CAL = 1'b0;
  localparam logic KIND_GAS = 1'b1;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD_RES,
    CFG_CLEAN_AIR,
    CFG_CAL_COUNT,
    CFG_READ_COUNT,
    CFG_LPG,
    CFG_CO,
    CFG_SMOKE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_MUL,
    LG_SQ
  } log_state_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RSDIV,
    S_ACC,
    S_CHK,
    S_AVGDIV,
    S_BRANCH,
    S_RODIV,
    S_LGA,
    S_LGB,
    S_LR,
    S_GAS,
    S_TDIV,
    S_VMUL,
    S_VRND,
    S_SRCH,
    S_SLOG,
    S_NEXT,
    S_OUT
  } top_state_e;

endpackage

### rtl/gsp_if.sv
`timescale 1ns / 1ps
interface gsp_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [gsp_pkg::ADC_FIELD_W-1:0] adc_sample;
  modport source (output valid, op, adc_sample, input ready);
  modport sink (input valid, op, adc_sample, output ready);
endinterface

interface gsp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [gsp_pkg::RES_W-1:0] ro_value;
  logic [gsp_pkg::RES_W-1:0] rs_value;
  logic [gsp_pkg::PPM_W-1:0] lpg_ppm;
  logic [gsp_pkg::PPM_W-1:0] co_ppm;
  logic [gsp_pkg::PPM_W-1:0] smoke_ppm;
  logic                      zero_sample_seen;
  modport source (output valid, kind, ro_value, rs_value, lpg_ppm, co_ppm, smoke_ppm,
                  zero_sample_seen, input ready);
  modport sink (input valid, kind, ro_value, rs_value, lpg_ppm, co_ppm, smoke_ppm,
                zero_sample_seen, output ready);
endinterface

interface gsp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gsp_pkg::CFG_IDX_W-1:0]  index;
  logic [gsp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/gsp_div.sv
`timescale 1ns / 1ps
module gsp_div #(
  parameter int N = gsp_pkg::DIV_NW,
  parameter int D = gsp_pkg::DIV_DW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int CW = $clog2(N);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [D-1:0]  rem_q, dv_q, rem_n;
  logic [N-1:0]  sh_q, sh_n;
  logic [D:0]    trial;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, sh_q[N-1]};
    ge    = trial >= {1'b0, dv_q};
    rem_n = ge ? D'(trial - {1'b0, dv_q}) : trial[D-1:0];
    sh_n  = {sh_q[N-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sh_q  <= dividend_i;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      sh_q  <= sh_n;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

### rtl/gsp_log2.sv
`timescale 1ns / 1ps
module gsp_log2 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gsp_pkg::LOG_IW-1:0]   value_i,
  output logic                         done_o,
  output logic [gsp_pkg::LOG_OW-1:0]   result_o
);

  gsp_pkg::log_state_e state_q, state_d;
  logic [31:0] m_q, m_d;
  logic [4:0]  e_q, e_d;
  logic [15:0] frac_q, frac_d;
  logic [63:0] prod_q, prod_d;
  logic [3:0]  it_q, it_d;
  logic        done_q, done_d;
  logic [32:0] m2;

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    e_d     = e_q;
    frac_d  = frac_q;
    prod_d  = prod_q;
    it_d    = it_q;
    done_d  = 1'b0;
    m2      = prod_q[63:31];
    unique case (state_q)
      gsp_pkg::LG_IDLE: begin
        if (start_i) begin
          m_d     = value_i;
          e_d     = 5'd31;
          frac_d  = '0;
          state_d = gsp_pkg::LG_NORM;
        end
      end
      gsp_pkg::LG_NORM: begin
        if (e_q != 5'd0 && !m_q[31]) begin
          m_d = {m_q[30:0], 1'b0};
          e_d = e_q - 5'd1;
        end else begin
          it_d    = '0;
          state_d = gsp_pkg::LG_MUL;
        end
      end
      gsp_pkg::LG_MUL: begin
        prod_d  = 64'(m_q) * 64'(m_q);
        state_d = gsp_pkg::LG_SQ;
      end
      gsp_pkg::LG_SQ: begin
        frac_d = {frac_q[14:0], m2[32]};
        m_d    = m2[32] ? m2[32:1] : m2[31:0];
        it_d   = it_q + 4'd1;
        if (it_q == 4'd15) begin
          done_d  = 1'b1;
          state_d = gsp_pkg::LG_IDLE;
        end else begin
          state_d = gsp_pkg::LG_MUL;
        end
      end
      default: state_d = gsp_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsp_pkg::LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    e_q    <= e_d;
    frac_q <= frac_d;
    prod_q <= prod_d;
    it_q   <= it_d;
  end

  assign done_o   = done_q;
  assign result_o = {e_q, frac_q};

endmodule

### rtl/gas_sensor_ppm_converter_unit.sv
`timescale 1ns / 1ps
// Gas sensor ppm converter. Each nonzero ADC sample becomes a sensor resistance
// through a bit-serial divider; a sample that closes a group adds an average
// divide. A calibration group then costs one more divide for Ro. A measurement
// group with nonzero average and Ro runs two log2 evaluations (each a normalizing
// shift of up to 31 steps and 16 squarings on one 32x32 multiplier) and, per gas
// with a nonzero slope, a divide plus a binary search, each step one log2
// evaluation. One transaction is in work at a time; a result waits in the output
// register while the next sample is taken. Configuration writes are always
// accepted and must be made while idle.
module gas_sensor_ppm_converter_unit #(
  parameter int ADC_BITS  = gsp_pkg::ADC_BITS_DEF,
  parameter int MAX_GROUP = gsp_pkg::MAX_GROUP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gsp_in_if.sink     sample_i,
  gsp_out_if.source  result_o,
  gsp_cfg_if.sink    cfg_i
);

  localparam int PW = 8 + ADC_BITS;
  localparam logic [ADC_BITS-1:0] ADC_FULL = '1;

  function automatic logic [gsp_pkg::RES_W-1:0] sat_res(input logic [gsp_pkg::DIV_NW-1:0] q);
    sat_res = (|q[gsp_pkg::DIV_NW-1:gsp_pkg::RES_W]) ? gsp_pkg::RES_MAX : q[gsp_pkg::RES_W-1:0];
  endfunction

  // configuration
  logic [7:0]  rl_q, calc_q, rdc_q;
  logic [15:0] caf_q;
  logic [47:0] lpg_q, co_q, smoke_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q    <= gsp_pkg::LOAD_RES_RESET;
      caf_q   <= gsp_pkg::CLEAN_AIR_RESET;
      calc_q  <= gsp_pkg::CAL_COUNT_RESET;
      rdc_q   <= gsp_pkg::READ_COUNT_RESET;
      lpg_q   <= gsp_pkg::LPG_RESET;
      co_q    <= gsp_pkg::CO_RESET;
      smoke_q <= gsp_pkg::SMOKE_RESET;
    end else if (cfg_i.valid) begin
      unique case (gsp_pkg::cfg_idx_e'(cfg_i.index))
        gsp_pkg::CFG_LOAD_RES:   rl_q    <= cfg_i.data[7:0];
        gsp_pkg::CFG_CLEAN_AIR:  caf_q   <= cfg_i.data[15:0];
        gsp_pkg::CFG_CAL_COUNT:  calc_q  <= cfg_i.data[7:0];
        gsp_pkg::CFG_READ_COUNT: rdc_q   <= cfg_i.data[7:0];
        gsp_pkg::CFG_LPG:        lpg_q   <= cfg_i.data;
        gsp_pkg::CFG_CO:         co_q    <= cfg_i.data;
        gsp_pkg::CFG_SMOKE:      smoke_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // shared units
  logic                          div_start, div_done;
  logic [gsp_pkg::DIV_NW-1:0]    div_num, div_quo;
  logic [gsp_pkg::DIV_DW-1:0]    div_den;
  logic                          lg_start, lg_done;
  logic [gsp_pkg::LOG_IW-1:0]    lg_val;
  logic [gsp_pkg::LOG_OW-1:0]    lg_res;

  gsp_div #(.N(gsp_pkg::DIV_NW), .D(gsp_pkg::DIV_DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_num), .divisor_i(div_den),
    .done_o(div_done), .quotient_o(div_quo)
  );

  gsp_log2 u_log2 (
    .clk_i, .rst_ni,
    .start_i(lg_start), .value_i(lg_val), .done_o(lg_done), .result_o(lg_res)
  );

  gsp_pkg::top_state_e state_q, state_d;
  logic [23:0] ro_q, ro_d, rs_q, rs_d;
  logic [31:0] sum_q, sum_d, avg_q, avg_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        cal_q, cal_d, zf_q, zf_d, kind_q, kind_d;
  logic [20:0] lga_q, lga_d;
  logic signed [37:0] lprod_q, lprod_d;
  logic signed [15:0] lr_q, lr_d;
  logic [1:0]  gas_q, gas_d;
  logic signed [30:0] t_q, t_d;
  logic signed [49:0] vprod_q, vprod_d;
  logic signed [38:0] v_q, v_d;
  logic [19:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [19:0] ppm_q [3];
  logic [19:0] ppm_d [3];

  logic        ov_q, ov_d, okind_q, okind_d, ozf_q, ozf_d;
  logic [23:0] oro_q, oro_d, ors_q, ors_d;
  logic [19:0] oppm_q [3];
  logic [19:0] oppm_d [3];

  // combinational datapath helpers
  logic [15:0]         adc_wide;
  logic [ADC_BITS-1:0] adc_in;
  logic [PW-1:0]       rs_prod;
  logic [7:0]          tgt_raw, tgt;
  logic [47:0]         curve;
  logic signed [15:0]  cx, cy, cs;
  logic signed [16:0]  nd;
  logic [16:0]         nmag;
  logic [15:0]         smag;
  logic                tneg;
  logic signed [30:0]  qs;
  logic signed [21:0]  ldiff;
  logic                lneg, vneg;
  logic [37:0]         lmag, lsum;
  logic [17:0]         lrnd;
  logic [49:0]         vmag, vsum;
  logic [37:0]         vr_mag;
  logic signed [38:0]  vr;
  logic [20:0]         span;
  logic [19:0]         mid;

  always_comb begin
    adc_wide = {6'b0, sample_i.adc_sample};
    adc_in   = adc_wide[ADC_BITS-1:0];
    rs_prod  = PW'(rl_q) * PW'(ADC_FULL - adc_in);

    tgt_raw = cal_q ? calc_q : rdc_q;
    tgt     = (tgt_raw == 8'd0) ? 8'd1 : tgt_raw;
    if (tgt > 8'(MAX_GROUP)) tgt = 8'(MAX_GROUP);

    unique case (gas_q)
      2'd0:    curve = lpg_q;
      2'd1:    curve = co_q;
      default: curve = smoke_q;
    endcase
    cx   = $signed(curve[47:32]);
    cy   = $signed(curve[31:16]);
    cs   = $signed(curve[15:0]);
    nd   = 17'(lr_q) - 17'(cy);
    nmag = nd[16] ? 17'(-nd) : 17'(nd);
    smag = cs[15] ? 16'(-cs) : 16'(cs);
    tneg = nd[16] ^ cs[15];
    qs   = $signed({2'b0, div_quo[28:0]});

    ldiff = $signed({1'b0, lga_q}) - $signed({1'b0, lg_res});
    lneg  = lprod_q[37];
    lmag  = lneg ? 38'(-lprod_q) : 38'(lprod_q);
    lsum  = lmag + 38'(1 << 19);
    lrnd  = lsum[37:20];

    vneg   = vprod_q[49];
    vmag   = vneg ? 50'(-vprod_q) : 50'(vprod_q);
    vsum   = vmag + 50'(2048);
    vr_mag = vsum[49:12];
    vr     = vneg ? -$signed({1'b0, vr_mag}) : $signed({1'b0, vr_mag});

    span = (21'(hi_q) - 21'(lo_q) + 21'd1) >> 1;
    mid  = 20'(span + 21'(lo_q));
  end

  always_comb begin
    state_d = state_q;
    ro_d = ro_q;   rs_d = rs_q;   sum_d = sum_q;  avg_d = avg_q;
    cnt_d = cnt_q; cal_d = cal_q; zf_d = zf_q;    kind_d = kind_q;
    lga_d = lga_q; lprod_d = lprod_q; lr_d = lr_q; gas_d = gas_q;
    t_d = t_q;     vprod_d = vprod_q; v_d = v_q;
    lo_d = lo_q;   hi_d = hi_q;   mid_d = mid_q;
    ppm_d = ppm_q;
    ov_d = ov_q && !result_o.ready;
    okind_d = okind_q; ozf_d = ozf_q; oro_d = oro_q; ors_d = ors_q;
    oppm_d = oppm_q;
    div_start = 1'b0; div_num = '0; div_den = '0;
    lg_start  = 1'b0; lg_val  = '0;

    unique case (state_q)
      gsp_pkg::S_IDLE: begin
        if (sample_i.valid) begin
          if (sample_i.op == gsp_pkg::OP_RESTART) begin
            cal_d = 1'b1;
            sum_d = '0;
            cnt_d = '0;
            zf_d  = 1'b0;
          end else if (adc_in == '0) begin
            rs_d    = gsp_pkg::RES_MAX;
            zf_d    = 1'b1;
            state_d = gsp_pkg::S_ACC;
          end else begin
            div_start = 1'b1;
            div_num   = gsp_pkg::DIV_NW'({rs_prod, 10'b0});
            div_den   = gsp_pkg::DIV_DW'(adc_in);
            state_d   = gsp_pkg::S_RSDIV;
          end
        end
      end
      gsp_pkg::S_RSDIV: begin
        if (div_done) begin
          rs_d    = sat_res(div_quo);
          state_d = gsp_pkg::S_ACC;
        end
      end
      gsp_pkg::S_ACC: begin
        sum_d   = sum_q + 32'(rs_q);
        cnt_d   = cnt_q + 8'd1;
        state_d = gsp_pkg::S_CHK;
      end
      gsp_pkg::S_CHK: begin
        if (cnt_q < tgt && cnt_q != 8'd0) begin
          state_d = gsp_pkg::S_IDLE;
        end else if (cnt_q == 8'd0) begin
          avg_d   = sum_q;
          state_d = gsp_pkg::S_BRANCH;
        end else begin
          div_start = 1'b1;
          div_num   = gsp_pkg::DIV_NW'(sum_q);
          div_den   = gsp_pkg::DIV_DW'(cnt_q);
          state_d   = gsp_pkg::S_AVGDIV;
        end
      end
      gsp_pkg::S_AVGDIV: begin
        if (div_done) begin
          avg_d   = div_quo[31:0];
          state_d = gsp_pkg::S_BRANCH;
        end
      end
      gsp_pkg::S_BRANCH: begin
        if (cal_q) begin
          div_start = 1'b1;
          div_num   = gsp_pkg::DIV_NW'({avg_q, 8'b0});
          div_den   = (caf_q == 16'd0) ? 16'd1 : caf_q;
          state_d   = gsp_pkg::S_RODIV;
        end else if (avg_q == 32'd0 || ro_q == 24'd0) begin
          if (avg_q == 32'd0 && ro_q == 24'd0) lr_d = 16'sd0;
          else if (avg_q == 32'd0)             lr_d = -16'sd32768;
          else                                 lr_d = 16'sd32767;
          gas_d   = 2'd0;
          state_d = gsp_pkg::S_GAS;
        end else begin
          lg_start = 1'b1;
          lg_val   = avg_q;
          state_d  = gsp_pkg::S_LGA;
        end
      end
      gsp_pkg::S_RODIV: begin
        if (div_done) begin
          ro_d     = sat_res(div_quo);
          cal_d    = 1'b0;
          kind_d   = gsp_pkg::KIND_CAL;
          ppm_d[0] = '0;
          ppm_d[1] = '0;
          ppm_d[2] = '0;
          state_d  = gsp_pkg::S_OUT;
        end
      end
      gsp_pkg::S_LGA: begin
        if (lg_done) begin
          lga_d    = lg_res;
          lg_start = 1'b1;
          lg_val   = 32'(ro_q);
          state_d  = gsp_pkg::S_LGB;
        end
      end
      gsp_pkg::S_LGB: begin
        if (lg_done) begin
          lprod_d = 38'(ldiff) * $signed({1'b0, gsp_pkg::LOG10_OF_2_Q16});
          state_d = gsp_pkg::S_LR;
        end
      end
      gsp_pkg::S_LR: begin
        if (!lneg) lr_d = (lrnd > 18'd32767) ? 16'sd32767 : $signed(lrnd[15:0]);
        else       lr_d = (lrnd > 18'd32768) ? -16'sd32768 : -$signed(lrnd[15:0]);
        gas_d   = 2'd0;
        state_d = gsp_pkg::S_GAS;
      end
      gsp_pkg::S_GAS: begin
        if (cs == 16'sd0) begin
          ppm_d[gas_q] = gsp_pkg::PPM_MAX;
          state_d      = gsp_pkg::S_NEXT;
        end else begin
          div_start = 1'b1;
          div_num   = gsp_pkg::DIV_NW'({nmag, 12'b0});
          div_den   = smag;
          state_d   = gsp_pkg::S_TDIV;
        end
      end
      gsp_pkg::S_TDIV: begin
        if (div_done) begin
          t_d     = (tneg ? -qs : qs) + 31'(cx);
          state_d = gsp_pkg::S_VMUL;
        end
      end
      gsp_pkg::S_VMUL: begin
        vprod_d = 50'(t_q) * $signed({1'b0, gsp_pkg::LOG2_OF_10_Q16});
        state_d = gsp_pkg::S_VRND;
      end
      gsp_pkg::S_VRND: begin
        v_d = vr;
        if (vr[38]) begin
          ppm_d[gas_q] = '0;
          state_d      = gsp_pkg::S_NEXT;
        end else begin
          lo_d    = 20'd1;
          hi_d    = gsp_pkg::PPM_MAX;
          state_d = gsp_pkg::S_SRCH;
        end
      end
      gsp_pkg::S_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d    = mid;
          lg_start = 1'b1;
          lg_val   = 32'(mid);
          state_d  = gsp_pkg::S_SLOG;
        end else begin
          ppm_d[gas_q] = lo_q;
          state_d      = gsp_pkg::S_NEXT;
        end
      end
      gsp_pkg::S_SLOG: begin
        if (lg_done) begin
          if ($signed({18'b0, lg_res}) <= v_q) lo_d = mid_q;
          else                                 hi_d = mid_q - 20'd1;
          state_d = gsp_pkg::S_SRCH;
        end
      end
      gsp_pkg::S_NEXT: begin
        if (gas_q == 2'd2) begin
          kind_d  = gsp_pkg::KIND_GAS;
          state_d = gsp_pkg::S_OUT;
        end else begin
          gas_d   = gas_q + 2'd1;
          state_d = gsp_pkg::S_GAS;
        end
      end
      gsp_pkg::S_OUT: begin
        if (!ov_q || result_o.ready) begin
          ov_d    = 1'b1;
          okind_d = kind_q;
          oro_d   = ro_q;
          ors_d   = avg_q[23:0];
          ozf_d   = zf_q;
          oppm_d  = ppm_q;
          sum_d   = '0;
          cnt_d   = '0;
          zf_d    = 1'b0;
          state_d = gsp_pkg::S_IDLE;
        end
      end
      default: state_d = gsp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsp_pkg::S_IDLE;
      ro_q    <= gsp_pkg::RO_RESET;
      sum_q   <= '0;
      cnt_q   <= '0;
      cal_q   <= 1'b1;
      zf_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ro_q    <= ro_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      cal_q   <= cal_d;
      zf_q    <= zf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q    <= rs_d;
    avg_q   <= avg_d;
    kind_q  <= kind_d;
    lga_q   <= lga_d;
    lprod_q <= lprod_d;
    lr_q    <= lr_d;
    gas_q   <= gas_d;
    t_q     <= t_d;
    vprod_q <= vprod_d;
    v_q     <= v_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    ppm_q   <= ppm_d;
    okind_q <= okind_d;
    oro_q   <= oro_d;
    ors_q   <= ors_d;
    ozf_q   <= ozf_d;
    oppm_q  <= oppm_d;
  end

  assign sample_i.ready           = (state_q == gsp_pkg::S_IDLE);
  assign result_o.valid            = ov_q;
  assign result_o.kind             = okind_q;
  assign result_o.ro_value         = oro_q;
  assign result_o.rs_value         = ors_q;
  assign result_o.lpg_ppm          = oppm_q[0];
  assign result_o.co_ppm           = oppm_q[1];
  assign result_o.smoke_ppm        = oppm_q[2];
  assign result_o.zero_sample_seen = ozf_q;

endmodule

### test/tb_gas_sensor_ppm_converter_unit.sv
`timescale 1ns / 1ps
module tb_gas_sensor_ppm_converter_unit;
  import gsp_pkg::*;

  localparam int unsigned ADC_FULL   = (1 << ADC_BITS_DEF) - 1;
  localparam longint      CYCLE_CAP  = 40_000_000;
  localparam int          SETTLE     = 300;

  typedef struct packed {
    logic             kind;
    logic [RES_W-1:0] ro_value;
    logic [RES_W-1:0] rs_value;
    logic [PPM_W-1:0] lpg_ppm;
    logic [PPM_W-1:0] co_ppm;
    logic [PPM_W-1:0] smoke_ppm;
    logic             zero_sample_seen;
  } ppm_result_t;

  class ppm_scoreboard;
    logic [7:0]  load_res, cal_cnt, rd_cnt;
    logic [15:0] caf;
    logic [47:0] curve [3];
    logic [23:0] ro;
    logic [31:0] rsum;
    logic [7:0]  cnt;
    bit          calibrating, zflag;
    ppm_result_t pending [$];
    int          errors, n_cal, n_gas, n_in;

    function new();
      load_res = LOAD_RES_RESET;
      caf      = CLEAN_AIR_RESET;
      cal_cnt  = CAL_COUNT_RESET;
      rd_cnt   = READ_COUNT_RESET;
      curve[0] = LPG_RESET;
      curve[1] = CO_RESET;
      curve[2] = SMOKE_RESET;
      ro       = RO_RESET;
      calibrating = 1;
      clear_group();
    endfunction

    function void clear_group();
      rsum  = 0;
      cnt   = 0;
      zflag = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [47:0] d);
      case (idx)
        CFG_LOAD_RES:   load_res = d[7:0];
        CFG_CLEAN_AIR:  caf      = d[15:0];
        CFG_CAL_COUNT:  cal_cnt  = d[7:0];
        CFG_READ_COUNT: rd_cnt   = d[7:0];
        CFG_LPG:        curve[0] = d;
        CFG_CO:         curve[1] = d;
        CFG_SMOKE:      curve[2] = d;
        default: ;
      endcase
    endfunction

    static function longint log2_q16(longint unsigned v);
      int e;
      longint unsigned m;
      longint frac;
      e = 31;
      frac = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      m = (v & 64'hFFFF_FFFF) << (31 - e);
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      return longint'(e) * 65536 + frac;
    endfunction

    static function longint round_shift(longint a, int s);
      longint unsigned mag;
      mag = (a < 0) ? longint'(-a) : a;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (a < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    static function logic [PPM_W-1:0] ppm_of(longint lr, logic [47:0] c);
      longint x, y, slope, t, v;
      int unsigned lo, hi, mid;
      x = longint'($signed(c[47:32]));
      y = longint'($signed(c[31:16]));
      slope = longint'($signed(c[15:0]));
      lo = 1;
      hi = 32'(PPM_MAX);
      if (slope == 0) return PPM_MAX;
      t = ((lr - y) * 4096) / slope + x;
      v = round_shift(t * 217706, 12);
      if (v < 0) return '0;
      if (log2_q16(PPM_MAX) <= v) return PPM_MAX;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (log2_q16(mid) <= v) lo = mid;
        else hi = mid - 1;
      end
      return lo[PPM_W-1:0];
    endfunction

    function void note_input(logic op, logic [ADC_FIELD_W-1:0] sample);
      int unsigned adc, target;
      longint unsigned q;
      logic [31:0] rs, avg;
      longint lr, ro_w;
      ppm_result_t r;
      n_in++;
      if (op == OP_RESTART) begin
        calibrating = 1;
        clear_group();
        return;
      end
      adc = sample & ADC_FULL;
      if (adc == 0) begin
        rs = 32'(RES_MAX);
        zflag = 1;
      end else begin
        q = ((longint'(load_res) * (ADC_FULL - adc)) << 10) / adc;
        rs = (q > RES_MAX) ? 32'(RES_MAX) : q[31:0];
      end
      rsum = rsum + rs;
      cnt = 8'(cnt + 1);
      target = calibrating ? 32'(cal_cnt) : 32'(rd_cnt);
      if (target < 1) target = 1;
      if (target > MAX_GROUP_DEF) target = MAX_GROUP_DEF;
      if (cnt < target && cnt != 0) return;
      avg = (cnt != 0) ? rsum / cnt : rsum;
      r = '0;
      r.rs_value = avg[23:0];
      r.zero_sample_seen = zflag;
      if (calibrating) begin
        q = (longint'(avg) << 8) / ((caf != 0) ? caf : 16'd1);
        ro = (q > RES_MAX) ? RES_MAX : q[23:0];
        calibrating = 0;
        r.kind = KIND_CAL;
        n_cal++;
      end else begin
        ro_w = longint'(ro);
        if (avg == 0) lr = -32768;
        else if (ro_w == 0) lr = 32767;
        else begin
          lr = round_shift((log2_q16(avg) - log2_q16(ro_w)) * 19728, 20);
          if (lr > 32767) lr = 32767;
          if (lr < -32768) lr = -32768;
        end
        if (avg == 0 && ro_w == 0) lr = 0;
        r.kind      = KIND_GAS;
        r.lpg_ppm   = ppm_of(lr, curve[0]);
        r.co_ppm    = ppm_of(lr, curve[1]);
        r.smoke_ppm = ppm_of(lr, curve[2]);
        n_gas++;
      end
      r.ro_value = ro;
      pending.push_back(r);
      clear_group();
    endfunction

    function void check(ppm_result_t got);
      ppm_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction kind=%0d rs=%0d", got.kind, got.rs_value);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.ro_value != e.ro_value) begin
        $error("ro_value: expected %0d actual %0d", e.ro_value, got.ro_value); errors++;
      end
      if (got.rs_value != e.rs_value) begin
        $error("rs_value: expected %0d actual %0d", e.rs_value, got.rs_value); errors++;
      end
      if (got.lpg_ppm != e.lpg_ppm) begin
        $error("lpg_ppm: expected %0d actual %0d", e.lpg_ppm, got.lpg_ppm); errors++;
      end
      if (got.co_ppm != e.co_ppm) begin
        $error("co_ppm: expected %0d actual %0d", e.co_ppm, got.co_ppm); errors++;
      end
      if (got.smoke_ppm != e.smoke_ppm) begin
        $error("smoke_ppm: expected %0d actual %0d", e.smoke_ppm, got.smoke_ppm); errors++;
      end
      if (got.zero_sample_seen != e.zero_sample_seen) begin
        $error("zero_sample_seen: expected %0d actual %0d", e.zero_sample_seen,
               got.zero_sample_seen);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  gsp_in_if  in_if ();
  gsp_out_if out_if ();
  gsp_cfg_if cfg_if ();

  gas_sensor_ppm_converter_unit uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (in_if),
    .result_o (out_if),
    .cfg_i    (cfg_if)
  );

  ppm_scoreboard sb = new();
  longint cycles = 0;
  int src_idle = 0;
  int rcv_stall = 0;
  int hold_left = 0;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (in_if.valid && in_if.ready) sb.note_input(in_if.op, in_if.adc_sample);
    if (out_if.valid && out_if.ready)
      sb.check('{out_if.kind, out_if.ro_value, out_if.rs_value, out_if.lpg_ppm,
                 out_if.co_ppm, out_if.smoke_ppm, out_if.zero_sample_seen});
  end

  // receiver, with long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  task automatic send_item(logic op, logic [ADC_FIELD_W-1:0] adc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.adc_sample <= adc;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [47:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, d);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic setup(logic [7:0] lr, logic [15:0] caf, logic [7:0] cal, logic [7:0] rd,
                       logic [47:0] c0, logic [47:0] c1, logic [47:0] c2);
    write_reg(CFG_LOAD_RES, 48'(lr));
    write_reg(CFG_CLEAN_AIR, 48'(caf));
    write_reg(CFG_CAL_COUNT, 48'(cal));
    write_reg(CFG_READ_COUNT, 48'(rd));
    write_reg(CFG_LPG, c0);
    write_reg(CFG_CO, c1);
    write_reg(CFG_SMOKE, c2);
  endtask

  function automatic logic [47:0] pick_curve(logic [47:0] base);
    logic [15:0] x, y, s;
    case ($urandom_range(2))
      0: return base;
      1: begin
        x = 16'($urandom_range(0, 16383));
        y = 16'($urandom_range(0, 8191)) - 16'd2048;
        s = -16'($urandom_range(1, 8191));
        if ($urandom_range(3) == 0) s = -s;
        return {x, y, s};
      end
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [ADC_FIELD_W-1:0] pick_adc();
    case ($urandom_range(9))
      0: return '0;
      1: return 10'd1023;
      2: return 10'($urandom_range(1, 15));
      3: return 10'($urandom_range(1000, 1023));
      default: return 10'($urandom);
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(49) == 0) send_item(OP_RESTART, 10'($urandom));
      else send_item(OP_SAMPLE, pick_adc());
    end
  endtask

  int phase_items [8] = '{280, 280, 40, 290, 290, 40, 300, 300};
  logic [7:0] phase_rd [8] = '{5, 255, 1, 12, 3, 0, 20, 8};
  logic [7:0] phase_cal [8] = '{3, 255, 1, 20, 1, 0, 7, 50};
  logic [15:0] phase_caf [8] = '{2516, 65535, 256, 1000, 0, 300, 40000, 2516};
  logic [7:0] phase_lr [8] = '{5, 255, 1, 100, 33, 200, 5, 1};

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_SAMPLE;
    in_if.adc_sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_LOAD_RES;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // directed
    setup(8'd5, 16'd2516, 8'd2, 8'd2, LPG_RESET, CO_RESET, SMOKE_RESET);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd1);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd0);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd512);
    send_item(OP_SAMPLE, 10'd300);
    send_item(OP_RESTART, 10'd1023);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd1023);
    send_item(OP_SAMPLE, 10'd512);
    send_item(OP_SAMPLE, 10'd512);
    send_item(OP_SAMPLE, 10'd0);
    send_item(OP_RESTART, 10'd0);
    send_item(OP_SAMPLE, 10'd700);
    send_item(OP_SAMPLE, 10'd650);
    drain();
    setup(8'd255, 16'd256, 8'd1, 8'd1, 48'h7FFF_8000_0000, 48'h8000_7FFF_7FFF,
          48'hFFFF_FFFF_8000);
    send_item(OP_SAMPLE, 10'd0);
    send_item(OP_SAMPLE, 10'd1);
    send_item(OP_SAMPLE, 10'd1022);
    send_item(OP_SAMPLE, 10'd400);
    drain();

    for (int p = 0; p < 8; p++) begin
      setup(phase_lr[p], phase_caf[p], phase_cal[p], phase_rd[p],
            pick_curve(LPG_RESET), pick_curve(CO_RESET), pick_curve(SMOKE_RESET));
      case (p % 4)
        0: begin src_idle = 0;  rcv_stall = 0;  end
        1: begin src_idle = 53; rcv_stall = 0;  end
        2: begin src_idle = 0;  rcv_stall = 53; end
        default: begin src_idle = 19; rcv_stall = 19; end
      endcase
      if (p == 0) hold_left = 6000;
      random_items(phase_items[p]);
      drain();
    end

    $display("sent %0d items: %0d calibration and %0d gas results checked",
             sb.n_in, sb.n_cal, sb.n_gas);
    $display("covered 10 register settings incl. extremes, restarts, zero samples, stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### gas_sensor_ppm_converter_unit.f
rtl/gsp_pkg.sv
rtl/gsp_if.sv
rtl/gsp_div.sv
rtl/gsp_log2.sv
rtl/gas_sensor_ppm_converter_unit.sv
test/tb_gas_sensor_ppm_converter_unit.sv
